@@ rtl/gtsa_pkg.sv @@
// ----------------------------------------------------------------------------
// gtsa_pkg
// Shared types and constants of the G-test statistic accumulator: payload
// structs, sequencer states, fixed-point widths and the ln2 constant.
// ----------------------------------------------------------------------------
package gtsa_pkg;

  // field widths
  localparam int OBS_W    = 16;
  localparam int EXP_W    = 24;
  localparam int THRESH_W = 16;
  localparam int SCORE_W  = 64;
  localparam int UNREL_W  = 13;

  // log2 datapath: input is O<<8 or E, both Q.8, 24 bits
  localparam int LOG_IN_W = 24;
  localparam int POS_W    = 5;
  localparam int MANT_W   = 32;
  localparam int FRAC_W   = 24;
  localparam int LOG_W    = POS_W + FRAC_W;
  localparam int CNT_W    = 5;
  localparam int PROD_W   = 2 * MANT_W;
  localparam int LN_W     = 29;
  localparam int TERM_W   = 38;

  localparam logic [POS_W-1:0]    POS_MAX      = POS_W'(LOG_IN_W - 1);
  localparam logic [CNT_W-1:0]    SQ_LAST      = CNT_W'(FRAC_W - 1);
  localparam logic [29:0]         LN2_Q30      = 30'd744261118;
  localparam logic [PROD_W-1:0]   LN_ROUND     = PROD_W'(64'd1 << 29);
  localparam logic [PROD_W-1:0]   TERM_ROUND   = PROD_W'(64'd128);
  localparam logic [UNREL_W-1:0]  UNREL_MAX    = {UNREL_W{1'b1}};
  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(5);
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  typedef struct packed {
    logic [OBS_W-1:0] observed_count;
    logic [EXP_W-1:0] expected_count;
    logic             last_cell;
  } in_item_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] g_score;
    logic [UNREL_W-1:0]        unreliable_cells;
    logic                      expected_zero_error;
  } out_item_t;

  // normalizer result: top set bit and Q1.31 mantissa
  typedef struct packed {
    logic [POS_W-1:0]  top_bit;
    logic [MANT_W-1:0] mant;
  } norm_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NORM,
    S_SQ,
    S_SQ_END,
    S_LN_MUL,
    S_LN_RES,
    S_TERM_MUL,
    S_TERM_RES,
    S_ACC,
    S_FINISH
  } state_t;

endpackage

@@ rtl/g_test_statistic_accumulator.sv @@
// ----------------------------------------------------------------------------
// g_test_statistic_accumulator
// Accumulates O*ln(O/E) over contingency table cells and emits the G2 score.
// Each nonzero cell with E != 0 takes two log2 passes on the shared
//   multiplier, 24 squarings each, plus accept, scaling, accumulation and
//   finish; a zero or E == 0 cell goes from accept straight to finish.
// A new cell is taken only in idle. A last cell's result is registered in
//   the finish step and holds the block while out_ready is low.
// Reset: sum, unreliable count and error flag clear; threshold returns to 5.
// ----------------------------------------------------------------------------
module g_test_statistic_accumulator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  gtsa_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gtsa_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gtsa_pkg::THRESH_W-1:0]     cfg_data
);

  gtsa_pkg::state_t state, state_next;

  logic [gtsa_pkg::THRESH_W-1:0]   threshold;
  logic [gtsa_pkg::OBS_W-1:0]      o_reg;
  logic [gtsa_pkg::EXP_W-1:0]      e_reg;
  logic                            last_reg;
  logic                            log_sel;
  logic [gtsa_pkg::POS_W-1:0]      p_reg;
  logic [gtsa_pkg::MANT_W-1:0]     m_reg;
  logic [gtsa_pkg::FRAC_W-1:0]     frac;
  logic [gtsa_pkg::CNT_W-1:0]      cnt;
  logic [gtsa_pkg::LOG_W-1:0]      lo_reg;
  logic [gtsa_pkg::LOG_W-1:0]      d_reg;
  logic                            neg_reg;
  logic [gtsa_pkg::LN_W-1:0]       ln_reg;
  logic [gtsa_pkg::TERM_W-1:0]     term_reg;
  logic signed [gtsa_pkg::SCORE_W-1:0] sum;
  logic [gtsa_pkg::UNREL_W-1:0]    unrel_cnt;
  logic                            err_seen;

  logic                            in_xfer;
  logic                            out_load;
  logic [gtsa_pkg::LOG_IN_W-1:0]   norm_x;
  gtsa_pkg::norm_t                 norm;
  logic [gtsa_pkg::MANT_W-1:0]     mul_a;
  logic [gtsa_pkg::MANT_W-1:0]     mul_b;
  logic [gtsa_pkg::PROD_W-1:0]     prod;
  logic                            sq_bit;
  logic [gtsa_pkg::MANT_W-1:0]     m_step;
  logic [gtsa_pkg::FRAC_W-1:0]     frac_next;
  logic [gtsa_pkg::LOG_W-1:0]      log_val;
  logic [gtsa_pkg::PROD_W-1:0]     ln_sum;
  logic [gtsa_pkg::PROD_W-1:0]     term_sum;
  logic signed [gtsa_pkg::SCORE_W:0] acc;
  logic signed [gtsa_pkg::SCORE_W-1:0] sum_next;
  logic signed [gtsa_pkg::SCORE_W-1:0] score;

  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state == gtsa_pkg::S_FINISH) && last_reg && (!out_valid || out_ready);

  // shared units
  assign norm_x = log_sel ? e_reg : {o_reg, 8'h00};

  gtsa_normalize u_norm (
    .x    (norm_x),
    .norm (norm)
  );

  gtsa_mult u_mult (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // one squaring step: m = (m*m) >> 31, renormalize when m >= 2.0
  assign sq_bit    = prod[gtsa_pkg::PROD_W-1];
  assign m_step    = sq_bit ? prod[63:32] : prod[62:31];
  assign frac_next = {frac[gtsa_pkg::FRAC_W-2:0], sq_bit};
  assign log_val   = {p_reg, frac_next};

  // rounding of ln and term magnitudes
  assign ln_sum   = prod + gtsa_pkg::LN_ROUND;
  assign term_sum = prod + gtsa_pkg::TERM_ROUND;

  // saturating accumulate
  always_comb begin
    acc = neg_reg ? ({sum[gtsa_pkg::SCORE_W-1], sum} - $signed({27'b0, term_reg}))
                  : ({sum[gtsa_pkg::SCORE_W-1], sum} + $signed({27'b0, term_reg}));
    if (acc[gtsa_pkg::SCORE_W] != acc[gtsa_pkg::SCORE_W-1]) begin
      sum_next = acc[gtsa_pkg::SCORE_W] ? gtsa_pkg::SCORE_MIN : gtsa_pkg::SCORE_MAX;
    end else begin
      sum_next = acc[gtsa_pkg::SCORE_W-1:0];
    end
  end

  // doubled score with saturation; error forces the top value
  always_comb begin
    if (err_seen) begin
      score = gtsa_pkg::SCORE_MAX;
    end else if (!sum[63] && sum[62]) begin
      score = gtsa_pkg::SCORE_MAX;
    end else if (sum[63] && !sum[62]) begin
      score = gtsa_pkg::SCORE_MIN;
    end else begin
      score = {sum[62:0], 1'b0};
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gtsa_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_data.observed_count == '0 || in_data.expected_count == '0)
            state_next = gtsa_pkg::S_FINISH;
          else
            state_next = gtsa_pkg::S_NORM;
        end
      end
      gtsa_pkg::S_NORM:     state_next = gtsa_pkg::S_SQ;
      gtsa_pkg::S_SQ: begin
        if (cnt == gtsa_pkg::SQ_LAST) state_next = gtsa_pkg::S_SQ_END;
      end
      gtsa_pkg::S_SQ_END:   state_next = log_sel ? gtsa_pkg::S_LN_MUL : gtsa_pkg::S_NORM;
      gtsa_pkg::S_LN_MUL:   state_next = gtsa_pkg::S_LN_RES;
      gtsa_pkg::S_LN_RES:   state_next = gtsa_pkg::S_TERM_MUL;
      gtsa_pkg::S_TERM_MUL: state_next = gtsa_pkg::S_TERM_RES;
      gtsa_pkg::S_TERM_RES: state_next = gtsa_pkg::S_ACC;
      gtsa_pkg::S_ACC:      state_next = gtsa_pkg::S_FINISH;
      gtsa_pkg::S_FINISH: begin
        if (!last_reg || out_load) state_next = gtsa_pkg::S_IDLE;
      end
      default:              state_next = gtsa_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: handshake and multiplier operand select
  always_comb begin
    in_ready = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      gtsa_pkg::S_IDLE: in_ready = 1'b1;
      gtsa_pkg::S_SQ: begin
        mul_a = (cnt == '0) ? m_reg : m_step;
        mul_b = (cnt == '0) ? m_reg : m_step;
      end
      gtsa_pkg::S_LN_MUL: begin
        mul_a = gtsa_pkg::MANT_W'(d_reg);
        mul_b = gtsa_pkg::MANT_W'(gtsa_pkg::LN2_Q30);
      end
      gtsa_pkg::S_TERM_MUL: begin
        mul_a = gtsa_pkg::MANT_W'(o_reg);
        mul_b = gtsa_pkg::MANT_W'(ln_reg);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gtsa_pkg::S_IDLE;
      threshold <= gtsa_pkg::THRESH_RESET;
      sum       <= '0;
      unrel_cnt <= '0;
      err_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) threshold <= cfg_data;

      // per-cell checks at input transfer
      if (in_xfer && in_data.observed_count != '0) begin
        if (in_data.expected_count == '0) err_seen <= 1'b1;
        if (in_data.observed_count < threshold && unrel_cnt != gtsa_pkg::UNREL_MAX)
          unrel_cnt <= unrel_cnt + 1'b1;
      end

      if (state == gtsa_pkg::S_ACC) sum <= sum_next;

      // result register; clears accumulator state on load
      if (out_load) begin
        out_valid <= 1'b1;
        sum       <= '0;
        unrel_cnt <= '0;
        err_seen  <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      o_reg    <= in_data.observed_count;
      e_reg    <= in_data.expected_count;
      last_reg <= in_data.last_cell;
      log_sel  <= 1'b0;
    end
    case (state)
      gtsa_pkg::S_NORM: begin
        p_reg <= norm.top_bit;
        m_reg <= norm.mant;
        frac  <= '0;
        cnt   <= '0;
      end
      gtsa_pkg::S_SQ: begin
        if (cnt != '0) frac <= frac_next;
        cnt <= cnt + 1'b1;
      end
      gtsa_pkg::S_SQ_END: begin
        if (!log_sel) begin
          lo_reg  <= log_val;
          log_sel <= 1'b1;
        end else begin
          neg_reg <= lo_reg < log_val;
          d_reg   <= (lo_reg < log_val) ? (log_val - lo_reg) : (lo_reg - log_val);
        end
      end
      gtsa_pkg::S_LN_RES:   ln_reg   <= ln_sum[58:30];
      gtsa_pkg::S_TERM_RES: term_reg <= term_sum[45:8];
      default: ;
    endcase
    if (out_load) begin
      out_data.g_score             <= score;
      out_data.unreliable_cells    <= unrel_cnt;
      out_data.expected_zero_error <= err_seen;
    end
  end

  // checks
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == gtsa_pkg::S_FINISH))
    else $error("result appeared outside the finish step");

  a_zero_cell_skips: assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_data.observed_count == '0 |=> state == gtsa_pkg::S_FINISH)
    else $error("zero cell entered the log datapath");

  a_error_score: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.expected_zero_error |-> out_data.g_score == gtsa_pkg::SCORE_MAX)
    else $error("error result without saturated score");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    $past(in_xfer) && !$past(rst) |-> !in_ready)
    else $error("input taken while a cell is in work");

endmodule

@@ rtl/gtsa_mult.sv @@
// ----------------------------------------------------------------------------
// gtsa_mult
// Shared 32x32 unsigned multiplier with a registered product. Used for the
// log2 squarings, the ln2 scaling and the observed-count weighting.
// ----------------------------------------------------------------------------
module gtsa_mult (
  input  logic                             clk,
  input  logic [gtsa_pkg::MANT_W-1:0]      a,
  input  logic [gtsa_pkg::MANT_W-1:0]      b,
  output logic [gtsa_pkg::PROD_W-1:0]      prod
);

  // product register, payload only
  always_ff @(posedge clk) begin
    prod <= gtsa_pkg::PROD_W'(a) * gtsa_pkg::PROD_W'(b);
  end

endmodule

@@ rtl/gtsa_normalize.sv @@
// ----------------------------------------------------------------------------
// gtsa_normalize
// Finds the top set bit of a nonzero 24-bit value and left-aligns it to a
// Q1.31 mantissa in [1,2).
// ----------------------------------------------------------------------------
module gtsa_normalize (
  input  logic [gtsa_pkg::LOG_IN_W-1:0] x,
  output gtsa_pkg::norm_t               norm
);

  logic [gtsa_pkg::POS_W-1:0]  pos;
  logic [gtsa_pkg::MANT_W-1:0] x_wide;

  // priority encode, highest set bit wins
  always_comb begin
    pos = '0;
    for (int i = 0; i < gtsa_pkg::LOG_IN_W; i++) begin
      if (x[i]) pos = gtsa_pkg::POS_W'(i);
    end
  end

  // x << (31 - pos) == (x << 8) << (23 - pos)
  assign x_wide       = {x, {(gtsa_pkg::MANT_W-gtsa_pkg::LOG_IN_W){1'b0}}};
  assign norm.top_bit = pos;
  assign norm.mant    = x_wide << (gtsa_pkg::POS_MAX - pos);

endmodule
